/* rtl/core/lpfd_pkg.sv */
`default_nettype none

package lpfd_pkg;

  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 12;
  localparam int LEN_W    = 13;
  localparam int RAWLEN_W = 16;

  // payload store size; index and length widths above are sized for it
  localparam int BUFFER_DEPTH = 4096;

  // request codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAKE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // decoder phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_READY   = 2'd2;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd4096;

  typedef struct packed {
    logic              accepted;
    logic              oversize_drop;
    logic              frame_valid;
    logic [BYTE_W-1:0] type_byte;
    logic [BYTE_W-1:0] frame_flags;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] read_data;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/length_prefixed_frame_decoder_unit.sv */
`default_nettype none

// Length-prefixed frame decoder.
// Input channel (in_valid_i / in_stall_o): one request item per cycle while
// in_stall_o is low: push a stream byte, take the ready frame, or read a
// payload byte by index. Every item produces exactly one result item on the
// output channel (out_valid_o / out_stall_i), in order.
// Config channel (cfg_valid_i / cfg_ready_o): writes max_payload_length;
// always ready; the user must write it only while the block is idle, as the block does not enforce it.
// From accept to result valid, the payload store is read with a registered
// port in the read stage; the result then enters a 3-entry output queue,
// whose head drives the output ports.
// Throughput: 1 item per cycle with no output stall; header/payload counters
// and the single store write port all update in the accept cycle.
// When the receiver stalls, results collect in the queue; in_stall_o rises
// (from registers only) once queue plus read stage hold 3 items.
// Reset: phase back to header hunting, counters and held header cleared,
// limit back to 4096, queue empty. The payload store is not cleared; only
// bytes already written for the current or last frame are ever returned.
module length_prefixed_frame_decoder_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [lpfd_pkg::KIND_W-1:0]      kind_i,
  input  wire  [lpfd_pkg::BYTE_W-1:0]      byte_in_i,
  input  wire  [lpfd_pkg::INDEX_W-1:0]     payload_index_i,
  // config channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [lpfd_pkg::LEN_W-1:0]       cfg_data_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             accepted_o,
  output logic                             oversize_drop_o,
  output logic                             frame_valid_o,
  output logic [lpfd_pkg::BYTE_W-1:0]      type_byte_o,
  output logic [lpfd_pkg::BYTE_W-1:0]      frame_flags_o,
  output logic [lpfd_pkg::LEN_W-1:0]       frame_length_o,
  output logic [lpfd_pkg::BYTE_W-1:0]      read_data_o
);

  import lpfd_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [RAWLEN_W:0] DEPTH_L = (RAWLEN_W+1)'(BUFFER_DEPTH);

  // ---------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------
  logic [LEN_W-1:0]  max_len_q;
  logic [1:0]        phase_q, phase_d;
  logic [1:0]        hdr_cnt_q, hdr_cnt_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [BYTE_W-1:0] flags_q, flags_d;
  logic [BYTE_W-1:0] len_lo_q, len_lo_d;
  logic [LEN_W-1:0]  pay_len_q, pay_len_d;
  logic [LEN_W-1:0]  pay_cnt_q, pay_cnt_d;

  logic              in_acc;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic              in_range;

  result_t           res;
  logic [RAWLEN_W-1:0] raw_len;
  logic              too_long;
  logic [LEN_W-1:0]  cnt_inc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & ~in_stall_o;

  assign raw_len  = {byte_in_i, len_lo_q};
  assign too_long = ({1'b0, raw_len} > {{(RAWLEN_W+1-LEN_W){1'b0}}, max_len_q})
                 || ({1'b0, raw_len} > DEPTH_L);
  assign cnt_inc  = pay_cnt_q + LEN_W'(1);

  // idx < count implies idx < depth, since count never exceeds depth
  assign in_range  = {1'b0, payload_index_i} < pay_cnt_q;
  assign mem_waddr = AW'(pay_cnt_q);
  assign mem_raddr = AW'(payload_index_i);

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    type_d    = type_q;
    flags_d   = flags_q;
    len_lo_d  = len_lo_q;
    pay_len_d = pay_len_q;
    pay_cnt_d = pay_cnt_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    res       = '0;

    unique case (kind_i)
      KIND_PUSH: begin
        if (phase_q != PH_READY) begin
          res.accepted = 1'b1;
          if (phase_q == PH_PAYLOAD) begin
            mem_we    = 1'b1;
            pay_cnt_d = cnt_inc;
            if (cnt_inc >= pay_len_q) begin
              phase_d = PH_READY;
            end
          end else begin
            unique case (hdr_cnt_q)
              2'd0: begin
                type_d    = byte_in_i;
                hdr_cnt_d = 2'd1;
              end
              2'd1: begin
                flags_d   = byte_in_i;
                hdr_cnt_d = 2'd2;
              end
              2'd2: begin
                len_lo_d  = byte_in_i;
                hdr_cnt_d = 2'd3;
              end
              default: begin
                hdr_cnt_d = 2'd0;
                pay_cnt_d = '0;
                if (too_long) begin
                  res.oversize_drop = 1'b1;
                  pay_len_d         = '0;
                  phase_d           = PH_HEADER;
                end else begin
                  // fits in 13 bits: bounded by the limit register
                  pay_len_d = LEN_W'(raw_len);
                  phase_d   = (raw_len == '0) ? PH_READY : PH_PAYLOAD;
                end
              end
            endcase
          end
        end
      end
      KIND_TAKE: begin
        if (phase_q == PH_READY) begin
          res.frame_valid  = 1'b1;
          res.type_byte    = type_q;
          res.frame_flags  = flags_q;
          res.frame_length = pay_len_q;
          phase_d          = PH_HEADER;
          hdr_cnt_d        = 2'd0;
        end
      end
      KIND_READ: begin
        mem_re = in_range;
      end
      default: begin
        // unused code: no state change, all-zero result
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= 2'd0;
      type_q    <= '0;
      flags_q   <= '0;
      len_lo_q  <= '0;
      pay_len_q <= '0;
      pay_cnt_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q   <= phase_d;
        hdr_cnt_q <= hdr_cnt_d;
        type_q    <= type_d;
        flags_q   <= flags_d;
        len_lo_q  <= len_lo_d;
        pay_len_q <= pay_len_d;
        pay_cnt_q <= pay_cnt_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload store: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [BYTE_W-1:0] mem_q [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && mem_we) begin
      mem_q[mem_waddr] <= byte_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Read stage: result fields wait here for the store data
  // ---------------------------------------------------------------------
  logic    s1_valid_q;
  logic    s1_rd_q;
  result_t s1_res_q;
  result_t s1_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q <= res;
      s1_rd_q  <= mem_re;
    end
  end

  always_comb begin
    s1_out           = s1_res_q;
    s1_out.read_data = s1_rd_q ? rdata_q : '0;
  end

  // ---------------------------------------------------------------------
  // Output queue, 3 entries; head drives the result ports
  // ---------------------------------------------------------------------
  result_t    fifo_q [3];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  result_t    head;

  assign push = s1_valid_q;
  assign pop  = out_valid_o & ~out_stall_i;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  // room check uses registers only: queue plus read stage must stay <= 3
  assign in_stall_o  = (cnt_q == 2'd3) || ((cnt_q == 2'd2) && s1_valid_q);
  assign out_valid_o = (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= s1_out;
    end
  end

  assign head = fifo_q[rd_ptr_q];

  assign accepted_o      = head.accepted;
  assign oversize_drop_o = head.oversize_drop;
  assign frame_valid_o   = head.frame_valid;
  assign type_byte_o     = head.type_byte;
  assign frame_flags_o   = head.frame_flags;
  assign frame_length_o  = head.frame_length;
  assign read_data_o     = head.read_data;

endmodule

`default_nettype wire
